// File: design/aclse_pkg.sv
// ----------------------------------------------------------------------------
// aclse_pkg
// Shared types and constants for the announcement-confirmed lease selector.
// ----------------------------------------------------------------------------
package aclse_pkg;

  // Default longest accepted lease, in seconds
  localparam int unsigned MAX_LEASE_DEFAULT = 300;

  localparam logic [15:0] MIN_LEASE_SECONDS = 16'd5;
  localparam logic [4:0]  ANNOUNCE_BYTES    = 5'd18;
  localparam logic [31:0] ANNOUNCE_MAGIC    = 32'h4C4F_434E;
  localparam logic [7:0]  ANNOUNCE_VERSION  = 8'd1;
  localparam logic [1:0]  CONFIRM_COUNT     = 2'd2;

  // Port widths
  localparam int unsigned IN_TDATA_W  = 184;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_ANNOUNCE = 2'd0,
    OP_TICK     = 2'd1,
    OP_ASSOC    = 2'd2,
    // spare code: changes nothing, only reports the selection
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SRC_FALLBACK   = 2'd0,
    SRC_DISCOVERED = 2'd1,
    SRC_OVERRIDE   = 2'd2
  } source_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FALLBACK_ADDR   = 3'd0,
    REG_FALLBACK_UDP    = 3'd1,
    REG_OVERRIDE_ENABLE = 3'd2,
    REG_OVERRIDE_ADDR   = 3'd3,
    REG_OVERRIDE_PORT   = 3'd4
  } reg_index_t;

  // Announcement fields that the checker inspects
  typedef struct packed {
    logic [4:0]  packet_length;
    logic [31:0] magic_word;
    logic [7:0]  version_byte;
    logic [7:0]  flag_byte;
    logic [15:0] announced_port;
    logic [15:0] lease_seconds;
    logic [31:0] trailer_word;
    logic [31:0] sender_addr;
  } ann_item_t;

  // One result item
  typedef struct packed {
    source_t     source;
    logic [31:0] selected_addr;
    logic [15:0] selected_port;
    logic        announce_valid;
    logic        discovery_confirmed;
  } result_t;

endpackage

// File: design/aclse_check.sv
// ----------------------------------------------------------------------------
// aclse_check
// Field-by-field validation of one received announcement.
// ----------------------------------------------------------------------------
module aclse_check #(
  parameter int unsigned MAX_LEASE_SECONDS = aclse_pkg::MAX_LEASE_DEFAULT
) (
  input  aclse_pkg::ann_item_t item,
  output logic                 ok
);
  import aclse_pkg::*;

  logic header_ok;
  logic lease_ok;
  logic sender_ok;

  always_comb begin
    header_ok = (item.packet_length == ANNOUNCE_BYTES) &&
                (item.magic_word == ANNOUNCE_MAGIC) &&
                (item.version_byte == ANNOUNCE_VERSION) &&
                (item.flag_byte == '0) &&
                (item.trailer_word == '0) &&
                (item.announced_port != '0);
    lease_ok  = (item.lease_seconds >= MIN_LEASE_SECONDS) &&
                (item.lease_seconds <= 16'(MAX_LEASE_SECONDS));
    // reject multicast (1110 prefix) and the all-zero address
    sender_ok = (item.sender_addr[31:28] != 4'b1110) && (item.sender_addr != '0);
    ok        = header_ok && lease_ok && sender_ok;
  end

endmodule

// File: design/announce_confirm_lease_select_unit.sv
// ----------------------------------------------------------------------------
// announce_confirm_lease_select_unit
// Collector destination selector with announcement-confirmed discovery.
// ----------------------------------------------------------------------------
// Each input item is one event: an announcement (tuser = 0), a one-second
// tick (1) or an association change (2); a code of 3 changes nothing. Every
// item yields exactly one result item carrying the selected destination:
// override if enabled, else the discovered collector while its lease runs,
// else the configured fallback. Announcements count only while associated;
// two valid ones in a row with identical address, port and nonce confirm
// discovery and load the lease countdown. The block takes one item per cycle
// while s_tready is high: all checks and the state update are a single
// level of compares between the state registers and the result register.
// A two-entry output buffer (result register plus skid register) lets an
// item be accepted while a previous result still waits; s_tready drops only
// when both entries are full. Configuration registers are written through
// cfg_wr_en / cfg_index / cfg_data and must only change while idle.
// ----------------------------------------------------------------------------
module announce_confirm_lease_select_unit #(
  parameter int unsigned MAX_LEASE_SECONDS = aclse_pkg::MAX_LEASE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [aclse_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [aclse_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata, low bit up: packet_length(5) magic_word(32) version_byte(8)
  // flag_byte(8) announced_port(16) lease_seconds(16) nonce_word(32)
  // trailer_word(32) sender_addr(32) associated(1), zero pad(2)
  input  logic [aclse_pkg::IN_TDATA_W-1:0]   s_tdata,
  // tuser: opcode(2)
  input  logic [1:0]                         s_tuser,
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata, low bit up: selected_addr(32) selected_port(16) announce_valid(1)
  // discovery_confirmed(1), zero pad(6)
  output logic [aclse_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // tuser: source(2)
  output logic [1:0]                         m_tuser
);
  import aclse_pkg::*;

  localparam int unsigned LEASE_W = $clog2(MAX_LEASE_SECONDS + 1);

  // configuration registers
  logic [31:0] fallback_addr;
  logic [15:0] fallback_udp;
  logic        override_enable;
  logic [31:0] override_addr;
  logic [15:0] override_port;

  // discovery state
  logic               link_associated, link_associated_next;
  logic               has_discovered, has_discovered_next;
  logic [31:0]        discovered_addr, discovered_addr_next;
  logic [15:0]        discovered_port, discovered_port_next;
  logic [LEASE_W-1:0] lease_remaining, lease_remaining_next;
  logic [31:0]        candidate_addr, candidate_addr_next;
  logic [15:0]        candidate_port, candidate_port_next;
  logic [31:0]        candidate_nonce, candidate_nonce_next;
  logic [1:0]         candidate_count, candidate_count_next;

  // output buffer
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;
  result_t res_next;

  logic      in_accept, out_pop;
  opcode_t   op;
  ann_item_t ann;
  logic      ann_ok;
  logic [31:0] nonce_in;
  logic        assoc_in;
  logic        same;
  logic [1:0]  count_sum;

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = out_valid && m_tready;

  // unpack the input item
  assign op                 = opcode_t'(s_tuser);
  assign ann.packet_length  = s_tdata[4:0];
  assign ann.magic_word     = s_tdata[36:5];
  assign ann.version_byte   = s_tdata[44:37];
  assign ann.flag_byte      = s_tdata[52:45];
  assign ann.announced_port = s_tdata[68:53];
  assign ann.lease_seconds  = s_tdata[84:69];
  assign nonce_in           = s_tdata[116:85];
  assign ann.trailer_word   = s_tdata[148:117];
  assign ann.sender_addr    = s_tdata[180:149];
  assign assoc_in           = s_tdata[181];

  aclse_check #(
    .MAX_LEASE_SECONDS (MAX_LEASE_SECONDS)
  ) u_check (
    .item (ann),
    .ok   (ann_ok)
  );

  // Event processing: next state and the result for the current item
  always_comb begin
    link_associated_next = link_associated;
    has_discovered_next  = has_discovered;
    discovered_addr_next = discovered_addr;
    discovered_port_next = discovered_port;
    lease_remaining_next = lease_remaining;
    candidate_addr_next  = candidate_addr;
    candidate_port_next  = candidate_port;
    candidate_nonce_next = candidate_nonce;
    candidate_count_next = candidate_count;
    res_next             = '0;

    same = (candidate_addr == ann.sender_addr) &&
           (candidate_port == ann.announced_port) &&
           (candidate_nonce == nonce_in);
    count_sum = same ? (candidate_count + 2'd1) : 2'd1;

    case (op)
      OP_ANNOUNCE: begin
        if (link_associated && ann_ok) begin
          res_next.announce_valid = 1'b1;
          candidate_addr_next     = ann.sender_addr;
          candidate_port_next     = ann.announced_port;
          candidate_nonce_next    = nonce_in;
          candidate_count_next    = count_sum;
          // second identical announcement in a row: confirm and load lease
          if (count_sum >= CONFIRM_COUNT) begin
            discovered_addr_next         = ann.sender_addr;
            discovered_port_next         = ann.announced_port;
            has_discovered_next          = 1'b1;
            lease_remaining_next         = ann.lease_seconds[LEASE_W-1:0];
            candidate_count_next         = '0;
            res_next.discovery_confirmed = 1'b1;
          end
        end
      end
      OP_TICK: begin
        // count down, hold at zero
        if (lease_remaining != '0) begin
          lease_remaining_next = lease_remaining - LEASE_W'(1);
        end
      end
      OP_ASSOC: begin
        link_associated_next = assoc_in;
        if (!assoc_in) begin
          has_discovered_next  = 1'b0;
          candidate_count_next = '0;
        end
      end
      default: ;
    endcase

    // destination priority: override, live discovery, fallback
    if (override_enable) begin
      res_next.source        = SRC_OVERRIDE;
      res_next.selected_addr = override_addr;
      res_next.selected_port = override_port;
    end else if (has_discovered_next && (lease_remaining_next != '0)) begin
      res_next.source        = SRC_DISCOVERED;
      res_next.selected_addr = discovered_addr_next;
      res_next.selected_port = discovered_port_next;
    end else begin
      res_next.source        = SRC_FALLBACK;
      res_next.selected_addr = fallback_addr;
      res_next.selected_port = fallback_udp;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_addr   <= '0;
      fallback_udp    <= '0;
      override_enable <= 1'b0;
      override_addr   <= '0;
      override_port   <= '0;
      link_associated <= 1'b0;
      has_discovered  <= 1'b0;
      discovered_addr <= '0;
      discovered_port <= '0;
      lease_remaining <= '0;
      candidate_addr  <= '0;
      candidate_port  <= '0;
      candidate_nonce <= '0;
      candidate_count <= '0;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (reg_index_t'(cfg_index))
          REG_FALLBACK_ADDR:   fallback_addr   <= cfg_data;
          REG_FALLBACK_UDP:    fallback_udp    <= cfg_data[15:0];
          REG_OVERRIDE_ENABLE: override_enable <= cfg_data[0];
          REG_OVERRIDE_ADDR:   override_addr   <= cfg_data;
          REG_OVERRIDE_PORT:   override_port   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        link_associated <= link_associated_next;
        has_discovered  <= has_discovered_next;
        discovered_addr <= discovered_addr_next;
        discovered_port <= discovered_port_next;
        lease_remaining <= lease_remaining_next;
        candidate_addr  <= candidate_addr_next;
        candidate_port  <= candidate_port_next;
        candidate_nonce <= candidate_nonce_next;
        candidate_count <= candidate_count_next;
      end
      // output buffer occupancy
      if (skid_valid) begin
        if (out_pop) begin
          skid_valid <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid && !out_pop) begin
          skid_valid <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output buffer payload: refill the result register from skid first
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_res <= skid_res;
      end
    end else if (in_accept) begin
      if (out_valid && !out_pop) begin
        skid_res <= res_next;
      end else begin
        out_res <= res_next;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.source;
  assign m_tdata  = {6'b0, out_res.discovery_confirmed, out_res.announce_valid,
                     out_res.selected_port, out_res.selected_addr};

  // A filled skid entry always sits behind a filled result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  // Discovery can only live while the link is associated
  a_disc_needs_link: assert property (@(posedge clk) disable iff (rst)
    has_discovered |-> link_associated)
    else $error("discovered destination kept without association");

  // Candidate count never reaches the confirm threshold between items
  a_count_below: assert property (@(posedge clk) disable iff (rst)
    candidate_count < CONFIRM_COUNT)
    else $error("candidate count left at or above confirm threshold");

  // A confirming item leaves a running lease behind it
  a_confirm_loads: assert property (@(posedge clk) disable iff (rst)
    (in_accept && res_next.discovery_confirmed) |=>
      (has_discovered && (lease_remaining != '0)))
    else $error("confirmation did not load a lease");

endmodule

// File: verif/tb_announce_confirm_lease_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_announce_confirm_lease_select_unit
// Self-checking bench for the announcement-confirmed collector selector.
// ----------------------------------------------------------------------------
// A clocked driver feeds events from a backlog queue and runs a behavioral
// predictor on every accepted item. A clocked monitor compares each result
// item field by field against the oldest prediction. The run starts with a
// directed pass over the announcement checks, lease expiry and disassociation,
// then goes through several register settings, each followed by a burst of
// random events that are mostly well-formed announcement runs and tick bursts.
// ----------------------------------------------------------------------------
module tb_announce_confirm_lease_select_unit;
  import aclse_pkg::*;

  // One event as the bench sees it; op is kept wide enough for the unused code
  typedef struct {
    logic [1:0]  op;
    logic [4:0]  pkt_len;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [15:0] port;
    logic [15:0] lease;
    logic [31:0] nonce;
    logic [31:0] trailer;
    logic [31:0] sender;
    logic        assoc;
  } event_item_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [1:0]             s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;

  event_item_t event_backlog[$];
  result_t     expected_selection[$];
  int          mismatch_count = 0;
  // percent of cycles in which each side holds off; zero gives a steady stretch
  int          idle_pct = 38;

  // Bench copy of the configuration registers
  logic [31:0] fb_addr  = '0;
  logic [15:0] fb_port  = '0;
  logic        ovr_en   = 1'b0;
  logic [31:0] ovr_addr = '0;
  logic [15:0] ovr_port = '0;

  // Bench copy of the selector state
  logic        link_up    = 1'b0;
  logic        peer_found = 1'b0;
  logic [31:0] found_addr = '0;
  logic [15:0] found_port = '0;
  logic [8:0]  lease_left = '0;
  logic [31:0] cand_addr  = '0;
  logic [15:0] cand_port  = '0;
  logic [31:0] cand_nonce = '0;
  logic [1:0]  cand_hits  = '0;

  // Small pool of collectors so that repeated announcements line up
  logic [31:0] peer_addr  [4];
  logic [15:0] peer_port  [4];
  logic [15:0] peer_lease [4];
  logic [31:0] peer_nonce [4];

  announce_confirm_lease_select_unit #(
    .MAX_LEASE_SECONDS (MAX_LEASE_DEFAULT)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #1 clk = ~clk;

  // Advance the bench state by one event and return the selection it yields
  function automatic result_t predict_selection(event_item_t ev);
    result_t sel;
    logic    well_formed;
    logic    same;
    sel.announce_valid      = 1'b0;
    sel.discovery_confirmed = 1'b0;
    if (ev.op == OP_ANNOUNCE) begin
      well_formed = ev.pkt_len == ANNOUNCE_BYTES && ev.magic == ANNOUNCE_MAGIC &&
                    ev.version == ANNOUNCE_VERSION && ev.flags == 8'd0 &&
                    ev.trailer == 32'd0 && ev.port != 16'd0 &&
                    ev.lease >= MIN_LEASE_SECONDS && ev.lease <= MAX_LEASE_DEFAULT &&
                    ev.sender[31:28] != 4'hE && ev.sender != 32'd0;
      if (link_up && well_formed) begin
        same = cand_addr == ev.sender && cand_port == ev.port && cand_nonce == ev.nonce;
        sel.announce_valid = 1'b1;
        cand_hits  = same ? cand_hits + 2'd1 : 2'd1;
        cand_addr  = ev.sender;
        cand_port  = ev.port;
        cand_nonce = ev.nonce;
        if (cand_hits >= CONFIRM_COUNT) begin
          found_addr = ev.sender;
          found_port = ev.port;
          peer_found = 1'b1;
          lease_left = ev.lease[8:0];
          cand_hits  = 2'd0;
          sel.discovery_confirmed = 1'b1;
        end
      end
    end else if (ev.op == OP_TICK) begin
      if (lease_left != 9'd0) lease_left = lease_left - 9'd1;
    end else if (ev.op == OP_ASSOC) begin
      link_up = ev.assoc;
      if (!link_up) begin
        peer_found = 1'b0;
        cand_hits  = 2'd0;
      end
    end
    if (ovr_en) begin
      sel.source        = SRC_OVERRIDE;
      sel.selected_addr = ovr_addr;
      sel.selected_port = ovr_port;
    end else if (peer_found && lease_left != 9'd0) begin
      sel.source        = SRC_DISCOVERED;
      sel.selected_addr = found_addr;
      sel.selected_port = found_port;
    end else begin
      sel.source        = SRC_FALLBACK;
      sel.selected_addr = fb_addr;
      sel.selected_port = fb_port;
    end
    return sel;
  endfunction

  function automatic event_item_t good_announce(logic [31:0] addr, logic [15:0] port,
                                                logic [15:0] lease, logic [31:0] nonce);
    event_item_t ev;
    ev.op      = OP_ANNOUNCE;
    ev.pkt_len = ANNOUNCE_BYTES;
    ev.magic   = ANNOUNCE_MAGIC;
    ev.version = ANNOUNCE_VERSION;
    ev.flags   = 8'd0;
    ev.port    = port;
    ev.lease   = lease;
    ev.nonce   = nonce;
    ev.trailer = 32'd0;
    ev.sender  = addr;
    ev.assoc   = 1'b0;
    return ev;
  endfunction

  function automatic event_item_t plain_event(logic [1:0] op, logic assoc);
    event_item_t ev;
    ev = good_announce(32'd0, 16'd0, 16'd0, 32'd0);
    ev.op    = op;
    ev.assoc = assoc;
    return ev;
  endfunction

  function automatic logic [31:0] random_unicast();
    logic [31:0] a;
    a = $urandom;
    if (a[31:28] == 4'hE) a[31] = 1'b0;
    if (a == 32'd0) a = 32'd1;
    return a;
  endfunction

  task automatic refresh_peer(int unsigned slot);
    peer_addr[slot]  = random_unicast();
    peer_port[slot]  = 16'($urandom_range(1, 65535));
    peer_nonce[slot] = $urandom;
    // mostly short leases so that ticks let them run out
    peer_lease[slot] = ($urandom_range(0, 4) == 0) ?
                       16'($urandom_range(5, MAX_LEASE_DEFAULT)) :
                       16'($urandom_range(5, 12));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Write one register; hold the enable for a single edge
  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_FALLBACK_ADDR:   fb_addr  = value;
      REG_FALLBACK_UDP:    fb_port  = value[15:0];
      REG_OVERRIDE_ENABLE: ovr_en   = value[0];
      REG_OVERRIDE_ADDR:   ovr_addr = value;
      REG_OVERRIDE_PORT:   ovr_port = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] fa, logic [15:0] fp, logic en,
                                logic [31:0] oa, logic [15:0] op);
    write_reg(REG_FALLBACK_ADDR, fa);
    write_reg(REG_FALLBACK_UDP, {16'd0, fp});
    write_reg(REG_OVERRIDE_ENABLE, {31'd0, en});
    write_reg(REG_OVERRIDE_ADDR, oa);
    write_reg(REG_OVERRIDE_PORT, {16'd0, op});
  endtask

  // Hold until every queued event went in and every result came back
  task automatic wait_drained();
    do @(negedge clk);
    while (event_backlog.size() != 0 || expected_selection.size() != 0);
  endtask

  // Queue random events: mostly announcement runs from the peer pool and
  // tick bursts, the rest association changes, broken frames and noise
  task automatic queue_random_events(int unsigned count);
    int unsigned made;
    int unsigned kind;
    int unsigned slot;
    int unsigned reps;
    logic [4:0]  bad_len;
    event_item_t ev;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 99);
      slot = $urandom_range(0, 3);
      if (kind < 40) begin
        if ($urandom_range(0, 7) == 0) refresh_peer(slot);
        else if ($urandom_range(0, 5) == 0) peer_nonce[slot] = $urandom;
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          event_backlog.push_back(good_announce(peer_addr[slot], peer_port[slot],
                                                peer_lease[slot], peer_nonce[slot]));
          made++;
        end
      end else if (kind < 65) begin
        reps = $urandom_range(1, 8);
        repeat (reps) begin
          event_backlog.push_back(plain_event(OP_TICK, 1'($urandom_range(0, 1))));
          made++;
        end
      end else if (kind < 72) begin
        event_backlog.push_back(plain_event(OP_ASSOC, $urandom_range(0, 3) != 0));
        made++;
      end else if (kind < 87) begin
        ev = good_announce(peer_addr[slot], peer_port[slot], peer_lease[slot],
                           peer_nonce[slot]);
        case ($urandom_range(0, 10))
          0: begin
            bad_len = 5'($urandom_range(1, 18));
            ev.pkt_len = (bad_len == ANNOUNCE_BYTES) ? 5'd19 : bad_len;
          end
          1: ev.magic   = ANNOUNCE_MAGIC ^ (32'd1 << $urandom_range(0, 31));
          2: ev.version = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
          3: ev.flags   = 8'($urandom_range(1, 255));
          4: ev.port    = 16'd0;
          5: ev.lease   = 16'($urandom_range(0, 4));
          6: ev.lease   = 16'($urandom_range(MAX_LEASE_DEFAULT + 1, 65535));
          7: ev.trailer = 32'd1 << $urandom_range(0, 31);
          8: ev.sender  = 32'd0;
          9: ev.sender  = {4'hE, 28'($urandom)};
          default: ev.trailer = $urandom | 32'd1;
        endcase
        event_backlog.push_back(ev);
        made++;
      end else begin
        ev.op      = 2'($urandom_range(0, 3));
        ev.pkt_len = 5'($urandom_range(1, 19));
        ev.magic   = $urandom;
        ev.version = 8'($urandom);
        ev.flags   = 8'($urandom);
        ev.port    = 16'($urandom);
        ev.lease   = 16'($urandom);
        ev.nonce   = $urandom;
        ev.trailer = $urandom;
        ev.sender  = $urandom;
        ev.assoc   = 1'($urandom_range(0, 1));
        event_backlog.push_back(ev);
        made++;
      end
    end
  endtask

  // Driver: present the oldest backlog item, hold it until taken, and run
  // the predictor at the edge where it is accepted
  always @(posedge clk) begin : drive_events
    event_item_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ev = event_backlog.pop_front();
        expected_selection.push_back(predict_selection(ev));
      end
      if (!s_tvalid || s_tready) begin
        if (event_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          ev = event_backlog[0];
          s_tvalid <= 1'b1;
          s_tuser  <= ev.op;
          s_tdata  <= {2'b00, ev.assoc, ev.sender, ev.trailer, ev.nonce, ev.lease,
                       ev.port, ev.flags, ev.version, ev.magic, ev.pkt_len};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result item against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_selection.size() == 0) begin
          report_mismatch("result with nothing outstanding", {30'd0, m_tuser}, 32'd0);
        end else begin
          want = expected_selection.pop_front();
          if (m_tuser != want.source)
            report_mismatch("source", {30'd0, m_tuser}, {30'd0, want.source});
          if (m_tdata[31:0] != want.selected_addr)
            report_mismatch("selected_addr", m_tdata[31:0], want.selected_addr);
          if (m_tdata[47:32] != want.selected_port)
            report_mismatch("selected_port", {16'd0, m_tdata[47:32]},
                            {16'd0, want.selected_port});
          if (m_tdata[48] != want.announce_valid)
            report_mismatch("announce_valid", {31'd0, m_tdata[48]},
                            {31'd0, want.announce_valid});
          if (m_tdata[49] != want.discovery_confirmed)
            report_mismatch("discovery_confirmed", {31'd0, m_tdata[49]},
                            {31'd0, want.discovery_confirmed});
          if (m_tdata[55:50] != 6'd0)
            report_mismatch("tdata pad", {26'd0, m_tdata[55:50]}, 32'd0);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  initial begin : stimulus
    event_item_t base;
    for (int i = 0; i < 4; i++) refresh_peer(i);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    apply_settings(32'h0A00_0001, 16'd4739, 1'b0, 32'hC0A8_0164, 16'd9000);

    // Directed pass: announcement checks, confirmation, lease run-out and
    // disassociation while a lease is still running
    @(negedge clk);
    base = good_announce(32'hDFFF_FFFF, 16'hFFFF, 16'd300, 32'hFFFF_FFFF);
    event_backlog.push_back(base);                       // dropped: link is down
    event_backlog.push_back(plain_event(OP_ASSOC, 1'b1));
    event_backlog.push_back(base);
    event_backlog.push_back(base);                       // second in a row confirms
    event_backlog.push_back(plain_event(OP_UNUSED, 1'b1)); // unused code reports only
    for (int k = 0; k < 13; k++) begin
      event_item_t bad;
      bad = base;
      case (k)
        0:  bad.pkt_len = 5'd19;
        1:  bad.pkt_len = 5'd17;
        2:  bad.magic   = ANNOUNCE_MAGIC ^ 32'h8000_0000;
        3:  bad.version = 8'd0;
        4:  bad.flags   = 8'h80;
        5:  bad.port    = 16'd0;
        6:  bad.lease   = 16'd4;
        7:  bad.lease   = 16'd301;
        8:  bad.trailer = 32'h8000_0000;
        9:  bad.sender  = 32'd0;
        10: bad.sender  = 32'hE000_0000;
        11: bad.sender  = 32'hEFFF_FFFF;
        default: bad.lease = 16'hFFFF;
      endcase
      event_backlog.push_back(bad);
    end
    // top nibble 1111 is unicast here; shortest lease
    base = good_announce(32'hF000_0000, 16'd1, 16'd5, 32'd0);
    event_backlog.push_back(base);
    event_backlog.push_back(base);
    event_backlog.push_back(plain_event(OP_TICK, 1'b0));
    event_backlog.push_back(plain_event(OP_TICK, 1'b0));
    event_backlog.push_back(plain_event(OP_ASSOC, 1'b0)); // drop discovery early
    repeat (4) event_backlog.push_back(plain_event(OP_TICK, 1'b1)); // last holds at 0

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(32'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        1: apply_settings(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'd0, 16'd1);
        2: apply_settings($urandom, 16'($urandom), 1'b1, $urandom, 16'd0);
        3: apply_settings(32'd0, 16'd0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        default: apply_settings($urandom, 16'($urandom), 1'b0, $urandom,
                                16'($urandom_range(1, 65535)));
      endcase
      // one phase runs with both sides always ready
      idle_pct = (phase == 1) ? 0 : 38;
      @(negedge clk);
      event_backlog.push_back(plain_event(OP_ASSOC, 1'b1));
      queue_random_events(400);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
